[rtl/core/i2w_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2w_pkg
// Shared types and word codes for the integer to word token converter.
// ----------------------------------------------------------------------------
package i2w_pkg;

  // payload widths
  localparam int VALUE_W    = 31;
  localparam int CODE_W     = 5;

  // decimal digit row, least significant digit first
  localparam int NUM_DIGITS = 10;
  localparam int NUM_GROUPS = 4;
  localparam int GROUP_SLOTS = 5;
  localparam int NUM_SLOTS  = NUM_GROUPS * GROUP_SLOTS;
  localparam int SLOT_W     = $clog2(NUM_SLOTS + 1);

  typedef logic [3:0] digit_t;
  typedef logic [NUM_DIGITS-1:0][3:0] digit_vec_t;
  typedef logic [CODE_W-1:0] code_t;

  // word codes
  localparam code_t CODE_ZERO      = 5'd0;
  localparam code_t CODE_TEEN_BASE = 5'd10;
  localparam code_t CODE_TENS_BASE = 5'd18;
  localparam code_t CODE_HUNDRED   = 5'd28;
  localparam code_t CODE_THOUSAND  = 5'd29;
  localparam code_t CODE_MILLION   = 5'd30;
  localparam code_t CODE_BILLION   = 5'd31;

  // slots inside one group, in spelling order
  localparam int SLOT_HDIGIT  = 0;
  localparam int SLOT_HUNDRED = 1;
  localparam int SLOT_TENS    = 2;
  localparam int SLOT_ONES    = 3;
  localparam int SLOT_SCALE   = 4;

  // control state of the top level
  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_CONVERT = 3'b010,
    ST_SPELL   = 3'b100
  } state_t;

  // top level to speller
  typedef struct packed {
    logic start;
    logic run;
  } spell_ctl_t;

  // speller to top level
  typedef struct packed {
    logic done;
  } spell_sts_t;

  // scale word that closes a nonzero group
  function automatic code_t scale_code(input logic [1:0] grp);
    code_t c;
    case (grp)
      2'd1:    c = CODE_THOUSAND;
      2'd2:    c = CODE_MILLION;
      2'd3:    c = CODE_BILLION;
      default: c = CODE_ZERO;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/i2w_value_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2w_value_if
// Channel carrying one integer to be spelled.
// ----------------------------------------------------------------------------
interface i2w_value_if;
  import i2w_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/core/i2w_word_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2w_word_if
// Channel carrying one word code and its end-of-number flag.
// ----------------------------------------------------------------------------
interface i2w_word_if;
  import i2w_pkg::*;

  logic  valid;
  logic  ready;
  code_t word_code;
  logic  last_word;

  modport source (output valid, output word_code, output last_word, input ready);
  modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

[rtl/core/i2w_bcd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2w_bcd_cell
// One decimal digit of the shift-and-add-3 converter row.
// ----------------------------------------------------------------------------
module i2w_bcd_cell (
  input  logic            clk,
  input  logic            clear,
  input  logic            shift,
  input  logic            shift_in,
  output logic            shift_out,
  output i2w_pkg::digit_t digit
);
  import i2w_pkg::*;

  digit_t digit_r;
  digit_t digit_nxt;
  digit_t adj;

  // add 3 when the digit would overflow after doubling
  always_comb begin
    adj = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  end

  assign shift_out = adj[3];

  always_comb begin
    digit_nxt = digit_r;
    if (clear) begin
      digit_nxt = '0;
    end else if (shift) begin
      digit_nxt = {adj[2:0], shift_in};
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

[rtl/core/i2w_speller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2w_speller
// Walks the word slots of the four groups and emits one word per cycle while out_word is not stalled.
// ----------------------------------------------------------------------------
module i2w_speller (
  input  logic                clk,
  input  logic                rst_n,
  input  i2w_pkg::digit_vec_t digits,
  input  i2w_pkg::spell_ctl_t ctl,
  output i2w_pkg::spell_sts_t sts,
  i2w_word_if.source          out_word
);
  import i2w_pkg::*;

  logic [NUM_SLOTS-1:0] present;
  code_t                slot_code [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] cand;
  logic [NUM_SLOTS-1:0] after;
  logic [SLOT_W-1:0]    cur;
  logic                 any_cand;
  logic                 is_last;
  code_t                cur_code;
  logic                 fire;

  logic [SLOT_W-1:0]    ptr_r;
  logic [SLOT_W-1:0]    ptr_nxt;
  logic                 valid_r;
  logic                 valid_nxt;
  code_t                code_r;
  code_t                code_nxt;
  logic                 last_r;
  logic                 last_nxt;

  // which slots carry a word, and the word each one carries
  always_comb begin
    digit_t h;
    digit_t t;
    digit_t o;
    int     base;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      base = (NUM_GROUPS - 1 - g) * GROUP_SLOTS;
      h    = (g == NUM_GROUPS - 1) ? 4'd0 : digits[g*3+2];
      t    = (g == NUM_GROUPS - 1) ? 4'd0 : digits[g*3+1];
      o    = digits[g*3];
      present[base+SLOT_HDIGIT]   = (h != 4'd0);
      present[base+SLOT_HUNDRED]  = (h != 4'd0);
      present[base+SLOT_TENS]     = (t != 4'd0);
      present[base+SLOT_ONES]     = (t != 4'd1) && (o != 4'd0);
      present[base+SLOT_SCALE]    = (g != 0) && ((h | t | o) != 4'd0);
      slot_code[base+SLOT_HDIGIT]  = {1'b0, h};
      slot_code[base+SLOT_HUNDRED] = CODE_HUNDRED;
      slot_code[base+SLOT_TENS]    = (t == 4'd1) ? CODE_TEEN_BASE + {1'b0, o}
                                                 : CODE_TENS_BASE + {1'b0, t};
      slot_code[base+SLOT_ONES]    = {1'b0, o};
      slot_code[base+SLOT_SCALE]   = scale_code(2'(g));
    end
  end

  // next present slot at or past the pointer
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cand[i] = present[i] && (SLOT_W'(i) >= ptr_r);
    end
    cur = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        cur = SLOT_W'(i);
      end
    end
    any_cand = |cand;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      after[i] = present[i] && (SLOT_W'(i) > cur);
    end
  end

  // a number of value zero has no present slot and spells Zero
  always_comb begin
    if (any_cand) begin
      cur_code = slot_code[cur[SLOT_W-1:0]];
      is_last  = ~|after;
    end else begin
      cur_code = CODE_ZERO;
      is_last  = 1'b1;
    end
  end

  assign fire = ctl.run && (!valid_r || out_word.ready);

  // pointer and output word register
  always_comb begin
    ptr_nxt   = ptr_r;
    valid_nxt = valid_r;
    code_nxt  = code_r;
    last_nxt  = last_r;
    if (out_word.ready) begin
      valid_nxt = 1'b0;
    end
    if (ctl.start) begin
      ptr_nxt = '0;
    end else if (fire) begin
      ptr_nxt   = cur + SLOT_W'(1);
      valid_nxt = 1'b1;
      code_nxt  = cur_code;
      last_nxt  = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ptr_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    last_r <= last_nxt;
  end

  assign sts.done           = fire && is_last;
  assign out_word.valid     = valid_r;
  assign out_word.word_code = code_r;
  assign out_word.last_word = last_r;

endmodule

[rtl/core/integer_to_word_tokens.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_word_tokens
// Spells a non-negative integer as a run of English word codes.
// ----------------------------------------------------------------------------
//  channel    dir  payload                  notes
//  in_value   in   value[30:0]              low INPUT_BITS bits used
//  out_word   out  word_code[4:0], last_word last_word set on final word
//
//  An item is taken while idle, then shifted through the row of digit cells,
//  which shift one binary bit in per cycle, then spelled out as 1 to 16
//  words through the single word output register. Stalls on out_word
//  stretch the spelling phase for as long as a waiting word is held off.
//  in_value.ready is high only while idle; the last word may still be
//  waiting in the output register when the next number is taken.
//  Reset is synchronous and clears the control state and the output valid.
// ----------------------------------------------------------------------------
module integer_to_word_tokens #(
  parameter int INPUT_BITS = 31
) (
  input logic        clk,
  input logic        rst_n,
  i2w_value_if.sink  in_value,
  i2w_word_if.source out_word
);
  import i2w_pkg::*;

  localparam int CNT_W = $clog2(INPUT_BITS + 1);

  state_t                state_r;
  state_t                state_nxt;
  logic [INPUT_BITS-1:0] bin_r;
  logic [INPUT_BITS-1:0] bin_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  accept;
  logic                  last_shift;
  logic                  shifting;
  logic [NUM_DIGITS:0]   carry;
  digit_vec_t            digits;
  spell_ctl_t            ctl;
  spell_sts_t            sts;

  assign accept     = in_value.valid && in_value.ready;
  assign shifting   = (state_r == ST_CONVERT);
  assign last_shift = shifting && (cnt_r == CNT_W'(INPUT_BITS - 1));
  assign in_value.ready = (state_r == ST_IDLE);

  // sequencer: load, convert, spell
  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          bin_nxt   = in_value.value[INPUT_BITS-1:0];
          cnt_nxt   = '0;
          state_nxt = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_shift) begin
          state_nxt = ST_SPELL;
        end
      end
      ST_SPELL: begin
        if (sts.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
  end

  // row of digit cells, binary msb enters at the low digit
  assign carry[0] = bin_r[INPUT_BITS-1];

  for (genvar d = 0; d < NUM_DIGITS; d++) begin : g_cell
    i2w_bcd_cell u_cell (
      .clk       (clk),
      .clear     (accept),
      .shift     (shifting),
      .shift_in  (carry[d]),
      .shift_out (carry[d+1]),
      .digit     (digits[d])
    );
  end

  // word emission
  assign ctl.start = last_shift;
  assign ctl.run   = (state_r == ST_SPELL);

  i2w_speller u_speller (
    .clk      (clk),
    .rst_n    (rst_n),
    .digits   (digits),
    .ctl      (ctl),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks integer_to_word_tokens. Integers go in on the value channel. A local
// speller works out the word codes each one should produce, and every word
// that leaves the block is compared with the oldest word still outstanding.
// Directed numbers come first, then random numbers. Both channels idle at
// random, and one long receiver hold-off backs the block up to its input.
// ----------------------------------------------------------------------------
module tb;
  import i2w_pkg::*;

  localparam int          HOLD_CYCLES = 300;
  localparam int          STALL_LIMIT = 4000;
  localparam int          DRAIN_WAIT  = 60;
  localparam int unsigned VALUE_MAX   = 32'd2147483647;

  typedef struct packed {
    code_t code;
    logic  last;
  } spelled_word_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC,
    RX_HEAVY
  } rx_mode_t;

  logic clk;
  logic rst_n;

  i2w_value_if value_ch ();
  i2w_word_if  word_ch ();

  spelled_word_t pending_words[$];
  int            mismatch_count = 0;
  int            burst_left     = 0;
  int            quiet_cycles   = 0;
  logic          hold_request   = 1'b0;

  integer_to_word_tokens #(.INPUT_BITS(31)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (value_ch),
    .out_word (word_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // expected words for one number, appended to the outstanding list
  function automatic void spell_number(input logic [VALUE_W-1:0] value);
    digit_t        digits[NUM_DIGITS];
    code_t         scale_word[4];
    spelled_word_t words[$];
    spelled_word_t w;
    int unsigned   rest;
    digit_t        h, t, o;
    rest = 32'(value);
    scale_word = '{CODE_ZERO, CODE_THOUSAND, CODE_MILLION, CODE_BILLION};
    w.last = 1'b0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digits[i] = digit_t'(rest % 10);
      rest = rest / 10;
    end
    if (value == '0) begin
      w.code = CODE_ZERO;
      words.push_back(w);
    end else begin
      for (int g = 3; g >= 0; g--) begin
        h = (g == 3) ? 4'd0 : digits[g*3+2];
        t = (g == 3) ? 4'd0 : digits[g*3+1];
        o = digits[g*3];
        if (h == 0 && t == 0 && o == 0) continue;
        if (h != 0) begin
          w.code = code_t'(h);
          words.push_back(w);
          w.code = CODE_HUNDRED;
          words.push_back(w);
        end
        if (t == 1) begin
          w.code = CODE_TEEN_BASE + code_t'(o);
          words.push_back(w);
        end else begin
          if (t >= 2) begin
            w.code = CODE_TENS_BASE + code_t'(t);
            words.push_back(w);
          end
          if (o != 0) begin
            w.code = code_t'(o);
            words.push_back(w);
          end
        end
        if (g != 0) begin
          w.code = scale_word[g];
          words.push_back(w);
        end
      end
    end
    words[words.size()-1].last = 1'b1;
    foreach (words[i]) pending_words.push_back(words[i]);
  endfunction

  // random number, mixing full range, group-built, small and round values
  function automatic logic [VALUE_W-1:0] random_value();
    longint      sum;
    int unsigned grp[3];
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 2) begin
      sum = $urandom & VALUE_MAX;
    end else if (pick <= 5) begin
      foreach (grp[i]) grp[i] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 999);
      sum = longint'($urandom_range(0, 2)) * 1000000000 + longint'(grp[2]) * 1000000 +
            longint'(grp[1]) * 1000 + grp[0];
      if (sum > VALUE_MAX) sum = sum - 1000000000;
    end else if (pick <= 7) begin
      sum = $urandom_range(0, 999);
    end else if (pick == 8) begin
      sum = $urandom_range(0, 99);
    end else begin
      sum = $urandom_range(1, 9);
      repeat ($urandom_range(0, 9)) sum = sum * 10;
      if (sum > VALUE_MAX) sum = 2000000000;
    end
    return sum[VALUE_W-1:0];
  endfunction

  // offer one number, wait for it to be taken, then maybe leave a gap
  task automatic send_value(input logic [VALUE_W-1:0] value);
    value_ch.valid <= 1'b1;
    value_ch.value <= value;
    do @(posedge clk); while (!value_ch.ready);
    spell_number(value);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      value_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  // sender stops until every outstanding word has come out
  task automatic wait_for_drain();
    value_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_small_numbers();
    int unsigned vals[11] = '{0, 1, 9, 10, 11, 15, 19, 20, 21, 45, 99};
    foreach (vals[i]) send_value(VALUE_W'(vals[i]));
  endtask

  task automatic test_hundreds();
    int unsigned vals[5] = '{100, 101, 110, 119, 999};
    foreach (vals[i]) send_value(VALUE_W'(vals[i]));
  endtask

  task automatic test_scale_words();
    int unsigned vals[6] = '{1000, 1010, 1000000, 1000000000, 1001001001, 2000000000};
    foreach (vals[i]) send_value(VALUE_W'(vals[i]));
  endtask

  // the largest value also sets every input bit
  task automatic test_largest_values();
    int unsigned vals[3] = '{1234567890, 1999999999, VALUE_MAX};
    foreach (vals[i]) send_value(VALUE_W'(vals[i]));
  endtask

  task automatic test_random_values(input int count);
    repeat (count) send_value(random_value());
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    wait_for_drain();
    hold_request = 1'b1;
    burst_left = 12;
    repeat (12) send_value(random_value());
  endtask

  // sender pauses for a full drain between short bursts
  task automatic test_drain_pause();
    repeat (4) begin
      repeat (5) send_value(random_value());
      wait_for_drain();
    end
  endtask

  // receiver stall pattern, with an occasional long hold-off on request
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       phase;
    mode = RX_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    word_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        word_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        word_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS:   word_ch.ready <= 1'b1;
          RX_RANDOM:   word_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: word_ch.ready <= (phase % 7 < 4);
          default:     word_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // compare each word leaving the block with the oldest outstanding one
  always @(posedge clk) begin
    spelled_word_t want;
    if (rst_n && word_ch.valid && word_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: word_code %0d last_word %0b",
               word_ch.word_code, word_ch.last_word);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        if (word_ch.word_code !== want.code) begin
          $error("word_code: expected %0d, got %0d", want.code, word_ch.word_code);
          mismatch_count++;
        end
        if (word_ch.last_word !== want.last) begin
          $error("last_word: expected %0b, got %0b", want.last, word_ch.last_word);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (value_ch.valid && value_ch.ready) || (word_ch.valid && word_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst_n <= 1'b0;
    value_ch.valid <= 1'b0;
    value_ch.value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_small_numbers();
    test_hundreds();
    test_scale_words();
    test_largest_values();
    test_random_values(200);
    test_output_backpressure();
    test_drain_pause();
    test_random_values(200);

    wait_for_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
